### rtl/pip_pkg.sv
// Package for the point-in-polygon test block: payload structs, opcodes, state codes,
// and sizing constants shared by the vertex cells, the edge unit and the top level.
// Depends on nothing.
package pip_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);
   localparam int COORD_W      = 32;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int PROD_W       = 2 * DIFF_W;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_TEST   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [1:0]                opcode;
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic status;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } vertex_type;

   typedef struct packed {
      logic load;
      logic rotate;
   } cell_ctrl_type;

   typedef struct packed {
      logic       valid;
      vertex_type vi;
      vertex_type vj;
   } edge_type;

   typedef struct packed {
      logic busy;
      logic parity;
   } eu_status_type;

endpackage

### rtl/pip_cell.sv
// One vertex cell of the storage chain: takes its left neighbor on an append and its
// right neighbor while the chain rotates during a test.
// Depends on pip_pkg.
module pip_cell (
   input  logic                   clock,
   input  pip_pkg::cell_ctrl_type ctrl,
   input  pip_pkg::vertex_type    load_data,
   input  pip_pkg::vertex_type    rotate_data,
   output pip_pkg::vertex_type    q
);

   pip_pkg::vertex_type vertex_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         vertex_ff <= load_data;
      end else if (ctrl.rotate) begin
         vertex_ff <= rotate_data;
      end
   end

   assign q = vertex_ff;

endmodule

### rtl/pip_edge_unit.sv
// Shared edge compare unit: a three-stage pipeline that checks whether an edge straddles
// the test point's y and whether the point lies left of the crossing, toggling the parity.
// Depends on pip_pkg.
module pip_edge_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear_inside,
   input  pip_pkg::vertex_type    point,
   input  pip_pkg::edge_type      edge_in,
   output pip_pkg::eu_status_type stat
);

   logic                               v1_ff;
   logic                               v2_ff;
   logic                               inside_ff;
   logic                               inside_in;
   logic                               straddle;
   logic                               left;
   logic                               dy_pos1_ff;
   logic                               dy_pos2_ff;
   logic signed [pip_pkg::DIFF_W-1:0]  a_ff;
   logic signed [pip_pkg::DIFF_W-1:0]  dy_ff;
   logic signed [pip_pkg::DIFF_W-1:0]  c_ff;
   logic signed [pip_pkg::DIFF_W-1:0]  d_ff;
   logic signed [pip_pkg::DIFF_W-1:0]  xi_e;
   logic signed [pip_pkg::DIFF_W-1:0]  yi_e;
   logic signed [pip_pkg::DIFF_W-1:0]  xj_e;
   logic signed [pip_pkg::DIFF_W-1:0]  yj_e;
   logic signed [pip_pkg::DIFF_W-1:0]  tx_e;
   logic signed [pip_pkg::DIFF_W-1:0]  ty_e;
   logic signed [pip_pkg::PROD_W-1:0]  p1_ff;
   logic signed [pip_pkg::PROD_W-1:0]  p2_ff;

   assign xi_e = {edge_in.vi.x[pip_pkg::COORD_W-1], edge_in.vi.x};
   assign yi_e = {edge_in.vi.y[pip_pkg::COORD_W-1], edge_in.vi.y};
   assign xj_e = {edge_in.vj.x[pip_pkg::COORD_W-1], edge_in.vj.x};
   assign yj_e = {edge_in.vj.y[pip_pkg::COORD_W-1], edge_in.vj.y};
   assign tx_e = {point.x[pip_pkg::COORD_W-1], point.x};
   assign ty_e = {point.y[pip_pkg::COORD_W-1], point.y};

   assign straddle = (edge_in.vi.y > point.y) != (edge_in.vj.y > point.y);

   always_ff @(posedge clock) begin
      a_ff       <= tx_e - xi_e;
      dy_ff      <= yj_e - yi_e;
      c_ff       <= xj_e - xi_e;
      d_ff       <= ty_e - yi_e;
      dy_pos1_ff <= yj_e > yi_e;
      p1_ff      <= a_ff * dy_ff;
      p2_ff      <= c_ff * d_ff;
      dy_pos2_ff <= dy_pos1_ff;
   end

   assign left = dy_pos2_ff ? (p1_ff < p2_ff) : (p1_ff > p2_ff);

   always_comb begin
      inside_in = inside_ff;
      if (clear_inside) begin
         inside_in = 1'b0;
      end else if (v2_ff && left) begin
         inside_in = !inside_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         inside_ff <= 1'b0;
      end else begin
         v1_ff     <= edge_in.valid && straddle;
         v2_ff     <= v1_ff;
         inside_ff <= inside_in;
      end
   end

   assign stat.busy   = v1_ff || v2_ff;
   assign stat.parity = inside_ff;

endmodule

### rtl/point_in_polygon_test_top.sv
// Even-odd ray-casting point-in-polygon test. Vertices sit in a chain of cells, one
// vertex per cell; a clear, an append or an unused opcode answers directly from the
// idle state, while a test rotates the whole chain once past a single edge compare
// unit and then waits in the drain state until that unit is empty before it answers.
// Depends on pip_pkg, pip_cell and pip_edge_unit.
module point_in_polygon_test_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pip_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pip_pkg::rsp_type rsp_data
);

   localparam int N = pip_pkg::MAX_VERTICES;
   localparam int W = pip_pkg::COUNT_W;

   pip_pkg::state_type     state_ff;
   pip_pkg::state_type     state_in;
   logic [W-1:0]           count_ff;
   logic [W-1:0]           count_in;
   logic [W-1:0]           step_ff;
   logic [W-1:0]           step_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   pip_pkg::rsp_type       rsp_ff;
   pip_pkg::rsp_type       rsp_in;
   pip_pkg::vertex_type    point_ff;
   pip_pkg::vertex_type    prev_ff;
   pip_pkg::vertex_type    first_ff;
   pip_pkg::vertex_type    req_vertex;
   pip_pkg::vertex_type    cell_q [N];
   pip_pkg::cell_ctrl_type cell_ctrl;
   pip_pkg::edge_type      edge_cmd;
   pip_pkg::eu_status_type eu_stat;
   logic                   accept;
   logic                   rsp_free;
   logic                   clear_inside;
   logic                   start_test;

   assign req_vertex.x = req_data.x_coord;
   assign req_vertex.y = req_data.y_coord;

   for (genvar k = 0; k < N; k++) begin : g_cell
      pip_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .load_data   ((k == 0) ? req_vertex : cell_q[(k + N - 1) % N]),
         .rotate_data (cell_q[(k + 1) % N]),
         .q           (cell_q[k])
      );
   end

   always_comb begin
      edge_cmd.valid = (state_ff == pip_pkg::ST_WALK) && (step_ff != '0) &&
                       (step_ff <= count_ff);
      edge_cmd.vi    = (step_ff == count_ff) ? first_ff : cell_q[0];
      edge_cmd.vj    = prev_ff;
   end

   pip_edge_unit u_edge (
      .clock        (clock),
      .reset        (reset),
      .clear_inside (clear_inside),
      .point        (point_ff),
      .edge_in      (edge_cmd),
      .stat         (eu_stat)
   );

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == pip_pkg::ST_IDLE) && rsp_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cell_ctrl    = '0;
      clear_inside = 1'b0;
      start_test   = 1'b0;
      unique case (state_ff)
         pip_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (pip_pkg::op_type'(req_data.opcode))
                  pip_pkg::OP_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                  end
                  pip_pkg::OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                     if (count_ff < W'(N)) begin
                        cell_ctrl.load = 1'b1;
                        count_in       = count_ff + 1'b1;
                     end else begin
                        rsp_in.status = 1'b1;
                     end
                  end
                  pip_pkg::OP_TEST: begin
                     step_in      = '0;
                     clear_inside = 1'b1;
                     start_test   = 1'b1;
                     state_in     = pip_pkg::ST_WALK;
                  end
                  pip_pkg::OP_NONE: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                  end
               endcase
            end
         end
         pip_pkg::ST_WALK: begin
            cell_ctrl.rotate = step_ff < W'(N);
            step_in          = W'(step_ff + 1'b1);
            if (step_ff == W'(N)) begin
               state_in = pip_pkg::ST_DRAIN;
            end
         end
         pip_pkg::ST_DRAIN: begin
            if (!eu_stat.busy && rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.inside_res = eu_stat.parity;
               rsp_in.status     = 1'b0;
               state_in          = pip_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pip_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pip_pkg::ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (start_test) begin
         point_ff <= req_vertex;
      end
      if (state_ff == pip_pkg::ST_WALK) begin
         prev_ff <= cell_q[0];
         if (step_ff == '0) begin
            first_ff <= cell_q[0];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= W'(N))
      else $error("Vertex count exceeds the cell chain length.");

   a_test_starts_walk : assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.opcode == pip_pkg::OP_TEST) |=>
      (state_ff == pip_pkg::ST_WALK && step_ff == '0))
      else $error("A test transaction did not start a walk at step zero.");

   a_walk_ends : assert property (@(posedge clock) disable iff (reset)
      (state_ff == pip_pkg::ST_WALK && step_ff == W'(N)) |=> state_ff == pip_pkg::ST_DRAIN)
      else $error("The walk did not end after one full rotation.");

   a_idle_unit_empty : assert property (@(posedge clock) disable iff (reset)
      state_ff == pip_pkg::ST_IDLE |-> !eu_stat.busy)
      else $error("The edge unit still holds work while the block is idle.");

   a_full_append : assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.opcode == pip_pkg::OP_APPEND && count_ff == W'(N)) |=>
      (rsp_valid_ff && rsp_ff.status && $stable(count_ff)))
      else $error("An append to a full store was not flagged.");

endmodule
